[rtl/descending_set_sorter_macros.svh]
// Assertion macros for the descending set sorter.
// Every macro expects clk and arst_n in the scope where it is used.
`ifndef DESCENDING_SET_SORTER_MACROS_SVH
`define DESCENDING_SET_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("descending_set_sorter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("descending_set_sorter: next-cycle check failed");

`endif

[rtl/dss_pkg.sv]
// Package for the descending set sorter: capacity, derived widths and state encoding.
// It has no dependencies.
package dss_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int DW = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

endpackage

[rtl/descending_set_sorter.sv]
// Descending set sorter: collects a set in a sorted memory and streams it out largest first.
// A value into an empty store is written at once; into a full store it only sets overflow;
// else smaller entries shift up one at a time over the memory's single read and write port.
// Closing a set enters ST_OUT_RD, ST_OUT_LD; results then go one per cycle while not stalled.
// Asynchronous active-low reset clears the count, the overflow flag and all control state.
// Depends on dss_pkg and descending_set_sorter_macros.svh.
`include "descending_set_sorter_macros.svh"

module descending_set_sorter
	import dss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic signed [DW-1:0] sample_value,
	input  logic                 final_of_set,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [DW-1:0] sorted_value,
	output logic                 last_of_run,
	output logic                 overflowed
);

	logic signed [DW-1:0] mem [MAX_ITEMS];

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          ovf_q, ovf_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] k_q, k_d;
	logic signed [DW-1:0] v_q;
	logic          fin_q;
	logic signed [DW-1:0] rd_data_q;

	logic          we;
	logic [AW-1:0] wa;
	logic signed [DW-1:0] wd;
	logic [AW-1:0] rd_addr;
	logic          out_load;
	logic          accept_in;
	logic          out_free;
	logic          last_hit;

	logic                 result_valid_q;
	logic signed [DW-1:0] sorted_value_q;
	logic                 last_q;
	logic                 overflowed_q;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept_in    = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign last_hit     = ((CW'(k_q) + CW'(1)) == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		wa       = pos_q;
		wd       = v_q;
		rd_addr  = k_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		ovf_d    = ovf_q;
		k_d      = k_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = cnt_q[AW-1:0] - AW'(1);
				k_d     = '0;
				if (accept_in) begin
					if (cnt_q == CW'(MAX_ITEMS)) begin
						ovf_d   = 1'b1;
						state_d = final_of_set ? ST_OUT_RD : ST_IDLE;
					end else if (cnt_q == '0) begin
						we      = 1'b1;
						wa      = '0;
						wd      = sample_value;
						cnt_d   = CW'(1);
						state_d = final_of_set ? ST_OUT_RD : ST_IDLE;
					end else begin
						pos_d   = cnt_q[AW-1:0];
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				rd_addr = pos_q - AW'(2);
				we      = 1'b1;
				wa      = pos_q;
				k_d     = '0;
				if (rd_data_q < v_q) begin
					wd    = rd_data_q;
					pos_d = pos_q - AW'(1);
					if (pos_q == AW'(1)) begin
						state_d = ST_PLACE;
					end
				end else begin
					wd      = v_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = fin_q ? ST_OUT_RD : ST_IDLE;
				end
			end
			ST_PLACE: begin
				we      = 1'b1;
				wa      = pos_q;
				wd      = v_q;
				k_d     = '0;
				cnt_d   = cnt_q + CW'(1);
				state_d = fin_q ? ST_OUT_RD : ST_IDLE;
			end
			ST_OUT_RD: begin
				rd_addr = k_q;
				state_d = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				rd_addr = k_q;
				if (out_free) begin
					out_load = 1'b1;
					rd_addr  = k_q + AW'(1);
					k_d      = k_q + AW'(1);
					if (last_hit) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			pos_q <= '0;
			k_q   <= '0;
			fin_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			ovf_q <= ovf_d;
			pos_q <= pos_d;
			k_q   <= k_d;
			if (accept_in) begin
				fin_q <= final_of_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			v_q <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sorted_value_q <= rd_data_q;
			last_q         <= last_hit;
			overflowed_q   <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign sorted_value = sorted_value_q;
	assign last_of_run  = last_q;
	assign overflowed   = overflowed_q;

	`DSS_ASSERT_IMP(a_count_bound, 1'b1, cnt_q <= CW'(MAX_ITEMS))
	`DSS_ASSERT_IMP(a_overflow_full, ovf_q, cnt_q == CW'(MAX_ITEMS))
	`DSS_ASSERT_IMP(a_shift_pos, state_q == ST_SHIFT, pos_q != '0)
	`DSS_ASSERT_NEXT(a_set_closed, out_load && last_hit, state_q == ST_IDLE && cnt_q == '0)

endmodule
